[rtl/core/ocv_pkg.sv]
// Shared types and constants of the orbit camera view matrix unit.
// Used by ocv_mul, ocv_ctrl and the top level; depends on nothing.
`default_nettype none

package ocv_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WB,
    ST_DONE
  } state_t;

  // Micro-operations, each one pass through the shared multiplier
  typedef enum logic [3:0] {
    OP_ZOOM,
    OP_SX2,
    OP_SP9,
    OP_SP7,
    OP_SP5,
    OP_SP3,
    OP_SV,
    OP_M0,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_EYE,
    OP_DOT
  } op_t;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_MAX_PITCH = 2'd0;
  localparam logic [1:0] REG_MIN_ZOOM  = 2'd1;
  localparam logic [1:0] REG_MAX_ZOOM  = 2'd2;

  // Sine polynomial coefficients, Q30
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569305;
  localparam logic [31:0] SIN_C7 = 32'd5026996;
  localparam logic [31:0] SIN_C9 = 32'd172273;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Sequencer control toward the datapath
  typedef struct packed {
    logic       idle;
    logic       issue;
    logic       wb;
    logic       publish;
    op_t        op;
    logic [3:0] cnt;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/core/ocv_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on ocv_pkg for operand widths.
`default_nettype none

module ocv_mul
  import ocv_pkg::*;
(
  input  wire                       clk,
  input  wire                       en,
  input  wire  signed [MUL_A_W-1:0] a,
  input  wire  signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  // Product register, loaded on issue
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ocv_ctrl.sv]
// Sequencer of the orbit camera unit: steps the micro-operation list,
// with an issue state and then a writeback state per multiply. Depends on ocv_pkg.
`default_nettype none

module ocv_ctrl
  import ocv_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_fire,
  input  wire  out_free,
  output ctl_t ctl
);

  state_t     state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_ZOOM;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and next operation
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_ISSUE;
          op_nxt    = OP_ZOOM;
          cnt_nxt   = 4'd0;
        end
      end
      ST_ISSUE: state_nxt = ST_WB;
      ST_WB: begin
        state_nxt = ST_ISSUE;
        unique case (op_r)
          OP_ZOOM: begin
            op_nxt  = OP_SX2;
            cnt_nxt = 4'd0;
          end
          OP_SX2: op_nxt = OP_SP9;
          OP_SP9: op_nxt = OP_SP7;
          OP_SP7: op_nxt = OP_SP5;
          OP_SP5: op_nxt = OP_SP3;
          OP_SP3: op_nxt = OP_SV;
          OP_SV: begin
            if (cnt_r < 4'd3) begin
              op_nxt  = OP_SX2;
              cnt_nxt = cnt_r + 4'd1;
            end else begin
              op_nxt  = OP_M0;
              cnt_nxt = 4'd0;
            end
          end
          OP_M0: op_nxt = OP_M1;
          OP_M1: op_nxt = OP_M2;
          OP_M2: op_nxt = OP_M3;
          OP_M3: begin
            op_nxt  = OP_EYE;
            cnt_nxt = 4'd0;
          end
          OP_EYE: begin
            if (cnt_r < 4'd2) begin
              cnt_nxt = cnt_r + 4'd1;
            end else begin
              op_nxt  = OP_DOT;
              cnt_nxt = 4'd0;
            end
          end
          OP_DOT: begin
            if (cnt_r < 4'd8) begin
              cnt_nxt = cnt_r + 4'd1;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: op_nxt = OP_ZOOM;
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl.idle    = 1'b0;
    ctl.issue   = 1'b0;
    ctl.wb      = 1'b0;
    ctl.publish = 1'b0;
    ctl.op      = op_r;
    ctl.cnt     = cnt_r;
    unique case (state_r)
      ST_IDLE:  ctl.idle    = 1'b1;
      ST_ISSUE: ctl.issue   = 1'b1;
      ST_WB:    ctl.wb      = 1'b1;
      ST_DONE:  ctl.publish = out_free;
      default:  ctl.idle    = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/orbit_camera_view_matrix_unit.sv]
// Top level of the orbit camera view matrix unit: state, datapath and ports.
// Depends on ocv_pkg, ocv_mul and ocv_ctrl.
`default_nettype none

// Orbit camera look-at unit. Each input transaction updates the target point,
// zoom, yaw and pitch, then one shared signed multiplier evaluates the four
// sines, the row products, the eye point and the nine dot-product terms under
// a small sequencer: 41 multiplies, each an issue step and then a writeback
// of the registered product. The sequencer then waits in its done state until
// the output register is free and loads it, and in_tready is low from
// acceptance until the sequencer is idle again, so no new item is taken before
// the last is computed. A finished result sits in an output register; the
// next item may be accepted while it waits, and its own result is held in the
// sequencer until that register is taken.
module orbit_camera_view_matrix_unit
  import ocv_pkg::*;
#(
  parameter int ANGLE_BITS         = 16,
  parameter int POSITION_FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  // configuration
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_addr,
  input  wire  [30:0]  cfg_wdata,
  // input stream
  input  wire          in_tvalid,
  output logic         in_tready,
  // target_x, target_y, target_z, zoom_step, yaw_step, pitch_step
  input  wire  [143:0] in_tdata,
  // kind
  input  wire  [0:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  wire          out_tready,
  // right_x, right_y, right_z, up_x, up_y, up_z, back_x, back_y, back_z,
  // shift_x, shift_y, shift_z
  output logic [239:0] out_tdata
);

  localparam int AB  = ANGLE_BITS;
  localparam int SW  = ((AB > 16) ? AB : 16) + 1;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam logic signed [SW-1:0] PITCH_CAP = SW'((1 << (AB - 2)) - 1);
  localparam logic [30:0] MIN_ZOOM_RST = 31'(1 << POSITION_FRAC_BITS);
  localparam logic [30:0] MAX_ZOOM_RST = 31'(100 << POSITION_FRAC_BITS);

  // Round a Q14-scaled value, half away from zero
  function automatic logic signed [MUL_P_W-1:0] round14(
    input logic signed [MUL_P_W-1:0] v
  );
    logic signed [MUL_P_W-1:0] mag;
    logic signed [MUL_P_W-1:0] r;
    mag = v[MUL_P_W-1] ? -v : v;
    r   = (mag + MUL_P_W'(8192)) >>> 14;
    return v[MUL_P_W-1] ? -r : r;
  endfunction

  ctl_t ctl;
  logic in_fire;
  logic out_free;

  // Configuration and camera state
  logic [13:0]              max_pitch_r;
  logic [30:0]              min_zoom_r;
  logic [30:0]              max_zoom_r;
  logic [31:0]              tgt_r [3];
  logic [30:0]              dist_r;
  logic [AB-1:0]            yaw_r;
  logic signed [AB-1:0]     pitch_r;
  logic signed [15:0]       dstep_r;

  // Working registers
  logic [30:0]              x_r;
  logic [30:0]              x2_r;
  logic [31:0]              p_r;
  logic                     neg_r;
  logic signed [15:0]       sin_r [4];
  logic signed [15:0]       m_r [4];
  logic signed [33:0]       eye_r [3];
  logic signed [51:0]       acc_r;
  logic [31:0]              shift_r [3];
  logic                     out_valid_r;
  logic [239:0]             out_data_r;

  // Multiplier interface
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready  = ctl.idle;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ocv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctl      (ctl)
  );

  ocv_mul u_mul (
    .clk    (clk),
    .en     (ctl.issue),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // Input field views
  logic signed [15:0] in_yaw;
  logic signed [15:0] in_pitch;
  assign in_yaw   = in_tdata[127:112];
  assign in_pitch = in_tdata[143:128];

  // Yaw wrap and pitch clamp
  logic signed [SW-1:0] yaw_ext;
  logic signed [SW-1:0] pitch_sum;
  logic signed [SW-1:0] lim;
  logic signed [SW-1:0] pitch_cl;
  always_comb begin
    yaw_ext   = SW'(in_yaw);
    pitch_sum = SW'(pitch_r) + SW'(in_pitch);
    lim       = SW'(signed'({1'b0, max_pitch_r}));
    if (lim > PITCH_CAP) begin
      lim = PITCH_CAP;
    end
    pitch_cl = pitch_sum;
    if (pitch_cl > lim) begin
      pitch_cl = lim;
    end
    if (pitch_cl < -lim) begin
      pitch_cl = -lim;
    end
  end

  // Sine argument for the current sine index
  logic [AB-1:0] ang;
  logic [AB-2:0] rq;
  logic [30:0]   x_new;
  always_comb begin
    case (ctl.cnt[1:0])
      2'd0:    ang = yaw_r;
      2'd1:    ang = yaw_r + QUARTER;
      2'd2:    ang = pitch_r;
      default: ang = pitch_r + QUARTER;
    endcase
    rq = {1'b0, ang[AB-3:0]};
    if (ang[AB-2]) begin
      rq = QUARTER[AB-2:0] - rq;
    end
    x_new = 31'(rq) << (32 - AB);
  end

  // Dot-product row and column for the current term
  logic [1:0]         dot_i;
  logic [1:0]         dot_j;
  logic signed [15:0] row_el;
  logic signed [15:0] back_el;
  always_comb begin
    case (ctl.cnt)
      4'd0:    begin dot_i = 2'd0; dot_j = 2'd0; end
      4'd1:    begin dot_i = 2'd0; dot_j = 2'd1; end
      4'd2:    begin dot_i = 2'd0; dot_j = 2'd2; end
      4'd3:    begin dot_i = 2'd1; dot_j = 2'd0; end
      4'd4:    begin dot_i = 2'd1; dot_j = 2'd1; end
      4'd5:    begin dot_i = 2'd1; dot_j = 2'd2; end
      4'd6:    begin dot_i = 2'd2; dot_j = 2'd0; end
      4'd7:    begin dot_i = 2'd2; dot_j = 2'd1; end
      default: begin dot_i = 2'd2; dot_j = 2'd2; end
    endcase
    case ({dot_i, dot_j})
      4'b0000: row_el = sin_r[0];
      4'b0001: row_el = 16'sd0;
      4'b0010: row_el = -sin_r[1];
      4'b0100: row_el = -m_r[0];
      4'b0101: row_el = sin_r[3];
      4'b0110: row_el = -m_r[1];
      4'b1000: row_el = m_r[2];
      4'b1001: row_el = sin_r[2];
      default: row_el = m_r[3];
    endcase
    case (ctl.cnt[1:0])
      2'd0:    back_el = m_r[2];
      2'd1:    back_el = sin_r[2];
      default: back_el = m_r[3];
    endcase
  end

  // Operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      OP_ZOOM: begin
        mul_a = MUL_A_W'(dist_r);
        mul_b = MUL_B_W'(18'sd32768 - 18'(dstep_r));
      end
      OP_SX2: begin
        mul_a = MUL_A_W'(x_new);
        mul_b = MUL_B_W'(x_new);
      end
      OP_SP9: begin
        mul_a = MUL_A_W'(x2_r);
        mul_b = signed'(SIN_C9);
      end
      OP_SP7, OP_SP5, OP_SP3: begin
        mul_a = MUL_A_W'(x2_r);
        mul_b = signed'(p_r);
      end
      OP_SV: begin
        mul_a = MUL_A_W'(x_r);
        mul_b = signed'(p_r);
      end
      OP_M0: begin
        mul_a = MUL_A_W'(sin_r[2]);
        mul_b = MUL_B_W'(sin_r[1]);
      end
      OP_M1: begin
        mul_a = MUL_A_W'(sin_r[2]);
        mul_b = MUL_B_W'(sin_r[0]);
      end
      OP_M2: begin
        mul_a = MUL_A_W'(sin_r[1]);
        mul_b = MUL_B_W'(sin_r[3]);
      end
      OP_M3: begin
        mul_a = MUL_A_W'(sin_r[0]);
        mul_b = MUL_B_W'(sin_r[3]);
      end
      OP_EYE: begin
        mul_a = MUL_A_W'(dist_r);
        mul_b = MUL_B_W'(back_el);
      end
      default: begin
        mul_a = eye_r[dot_j];
        mul_b = MUL_B_W'(row_el);
      end
    endcase
  end

  // Writeback helpers
  logic [32:0]               zoom_q;
  logic [32:0]               sin_v;
  logic [32:0]               sin_rnd;
  logic [15:0]               sin_mag;
  logic signed [MUL_P_W-1:0] prod_r14;
  logic signed [51:0]        dot_sum;
  logic signed [MUL_P_W-1:0] dot_neg;
  logic [31:0]               dot_sat;
  always_comb begin
    zoom_q = 33'((prod[47:0] + 48'd16384) >> 15);
    if (zoom_q > {2'b00, max_zoom_r}) begin
      zoom_q = {2'b00, max_zoom_r};
    end
    if (zoom_q < {2'b00, min_zoom_r}) begin
      zoom_q = {2'b00, min_zoom_r};
    end
    sin_v   = prod[62:30];
    sin_rnd = (sin_v + 33'd32768) >> 16;
    sin_mag = (sin_rnd > 33'd16384) ? 16'd16384 : sin_rnd[15:0];
    prod_r14 = round14(prod);
    dot_sum  = ((dot_j == 2'd0) ? 52'sd0 : acc_r) + prod[51:0];
    dot_neg  = -round14(MUL_P_W'(dot_sum));
    if (dot_neg > MUL_P_W'(64'sd2147483647)) begin
      dot_sat = 32'h7FFF_FFFF;
    end else if (dot_neg < -MUL_P_W'(64'sd2147483648)) begin
      dot_sat = 32'h8000_0000;
    end else begin
      dot_sat = dot_neg[31:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pitch_r <= 14'd14563;
      min_zoom_r  <= MIN_ZOOM_RST;
      max_zoom_r  <= MAX_ZOOM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_PITCH: max_pitch_r <= cfg_wdata[13:0];
        REG_MIN_ZOOM:  min_zoom_r  <= cfg_wdata;
        REG_MAX_ZOOM:  max_zoom_r  <= cfg_wdata;
        default:       max_pitch_r <= max_pitch_r;
      endcase
    end
  end

  // Camera state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        tgt_r[i] <= '0;
      end
      dist_r  <= '0;
      yaw_r   <= '0;
      pitch_r <= '0;
    end else begin
      if (in_fire) begin
        for (int i = 0; i < 3; i++) begin
          tgt_r[i] <= in_tuser[0] ? in_tdata[32*i +: 32]
                                  : tgt_r[i] + in_tdata[32*i +: 32];
        end
        yaw_r   <= yaw_r + yaw_ext[AB-1:0];
        pitch_r <= pitch_cl[AB-1:0];
      end
      if (ctl.wb && ctl.op == OP_ZOOM) begin
        dist_r <= zoom_q[30:0];
      end
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dstep_r <= in_tdata[111:96];
    end
    if (ctl.issue && ctl.op == OP_SX2) begin
      x_r   <= x_new;
      neg_r <= ang[AB-1];
    end
    if (ctl.wb) begin
      case (ctl.op)
        OP_SX2: x2_r <= prod[60:30];
        OP_SP9: p_r  <= SIN_C7 - prod[61:30];
        OP_SP7: p_r  <= SIN_C5 - prod[61:30];
        OP_SP5: p_r  <= SIN_C3 - prod[61:30];
        OP_SP3: p_r  <= SIN_C1 - prod[61:30];
        OP_SV:  sin_r[ctl.cnt[1:0]] <= neg_r ? -signed'(sin_mag) : signed'(sin_mag);
        OP_M0:  m_r[0] <= prod_r14[15:0];
        OP_M1:  m_r[1] <= prod_r14[15:0];
        OP_M2:  m_r[2] <= prod_r14[15:0];
        OP_M3:  m_r[3] <= prod_r14[15:0];
        OP_EYE: eye_r[ctl.cnt[1:0]] <= 34'(signed'(tgt_r[ctl.cnt[1:0]]))
                                       + prod_r14[33:0];
        OP_DOT: begin
          acc_r <= dot_sum;
          if (dot_j == 2'd2) begin
            shift_r[dot_i] <= dot_sat;
          end
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_data_r <= {shift_r[2], shift_r[1], shift_r[0],
                     m_r[3], sin_r[2], m_r[2],
                     -m_r[1], sin_r[3], -m_r[0],
                     -sin_r[1], 16'sd0, sin_r[0]};
    end
  end

endmodule

`default_nettype wire
